### src/lss_pkg.sv
// ----------------------------------------------------------------------------
// Lattice sphere cell selector package
// Shared types, constants and helper functions for the cell selector.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int OFFSET_BITS = 8;

    localparam int COMP_BITS  = 21;
    localparam int VEC_W      = 3 * COMP_BITS;
    localparam int RADIUS_W   = 20;
    localparam int STRIDE_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VEC_W;

    localparam int POS_W      = 28;
    localparam int DIST_OUT_W = 58;
    localparam int FLAT_W     = 28;
    localparam int SLOT_W     = 24;

    localparam int LANES   = 3;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;

    localparam int POS_ACC_W = OFFSET_BITS + COMP_BITS + 2;
    localparam int LP_W      = COMP_BITS + 2;
    localparam int DF_W      = POS_ACC_W + 1;
    localparam int MAG_W     = 30;
    localparam int DSUM_W    = 2 * MAG_W;
    localparam int R2_W      = 2 * RADIUS_W;
    localparam int SYZ_W     = 2 * STRIDE_W;

    localparam longint unsigned DIST_CAP_VAL = 64'd100000 << (2 * FRAC_BITS);
    localparam int BEST_W = $clog2(DIST_CAP_VAL + 1);
    localparam int CMP_W  = (BEST_W > R2_W) ? BEST_W : R2_W;
    localparam logic [BEST_W-1:0] DIST_CAP = BEST_W'(DIST_CAP_VAL);
    localparam logic [DF_W-1:0] DIFF_CLAMP = DF_W'(1) << (MAG_W - 1);

    localparam logic signed [POS_ACC_W-1:0] POS_HI = POS_ACC_W'(2 ** (POS_W - 1) - 1);
    localparam logic signed [POS_ACC_W-1:0] POS_LO = POS_ACC_W'(-(2 ** (POS_W - 1)));

    localparam logic [CFG_IDX_W-1:0] REG_CELL_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Z = 3'd5;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] TERM_A = 2'd0;
    localparam logic [1:0] TERM_B = 2'd1;
    localparam logic [1:0] TERM_C = 2'd2;

    localparam logic [1:0] NB_NEG  = 2'd0;
    localparam logic [1:0] NB_ZERO = 2'd1;
    localparam logic [1:0] NB_POS  = 2'd2;

    typedef struct packed {
        logic signed [OFFSET_BITS-1:0] offset_i;
        logic signed [OFFSET_BITS-1:0] offset_j;
        logic signed [OFFSET_BITS-1:0] offset_k;
        logic                          restart;
    } in_item_t;

    typedef struct packed {
        logic                     inside_res;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic [DIST_OUT_W-1:0]    min_dist_sq;
        logic signed [FLAT_W-1:0] flat_index;
        logic [SLOT_W-1:0]        slot;
    } out_item_t;

    typedef struct packed {
        logic [VEC_W-1:0]    vec_a;
        logic [VEC_W-1:0]    vec_b;
        logic [VEC_W-1:0]    vec_c;
        logic [RADIUS_W-1:0] radius;
        logic [STRIDE_W-1:0] stride_y;
        logic [STRIDE_W-1:0] stride_z;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_POS,
        OP_MISC,
        OP_FLAT,
        OP_DIST
    } mul_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_MISC,
        S_FLAT,
        S_DIST,
        S_DRAIN,
        S_DONE
    } state_t;

    function automatic logic signed [COMP_BITS-1:0] get_comp(input logic [VEC_W-1:0] v,
                                                            input logic [1:0] axis);
        logic signed [COMP_BITS-1:0] r;
        case (axis)
            AX_X:    r = v[COMP_BITS-1:0];
            AX_Y:    r = v[2*COMP_BITS-1:COMP_BITS];
            AX_Z:    r = v[3*COMP_BITS-1:2*COMP_BITS];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [LP_W-1:0] lat_term(input logic [1:0] idx,
                                                        input logic signed [COMP_BITS-1:0] c);
        logic signed [LP_W-1:0] r;
        case (idx)
            NB_NEG:  r = -LP_W'(c);
            NB_POS:  r = LP_W'(c);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_ACC_W-1:0] v);
        logic signed [POS_ACC_W-1:0] s;
        s = v;
        if (v > POS_HI)
            s = POS_HI;
        if (v < POS_LO)
            s = POS_LO;
        return POS_W'(s);
    endfunction

endpackage

### src/lss_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the cell vectors, the cutoff radius and the grid strides.
// ----------------------------------------------------------------------------
module lss_cfg_regs import lss_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_A:   cfg_next.vec_a    = cfg_data[VEC_W-1:0];
                REG_CELL_B:   cfg_next.vec_b    = cfg_data[VEC_W-1:0];
                REG_CELL_C:   cfg_next.vec_c    = cfg_data[VEC_W-1:0];
                REG_RADIUS:   cfg_next.radius   = cfg_data[RADIUS_W-1:0];
                REG_STRIDE_Y: cfg_next.stride_y = cfg_data[STRIDE_W-1:0];
                REG_STRIDE_Z: cfg_next.stride_z = cfg_data[STRIDE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vec_a    <= '0;
            cfg_reg.vec_b    <= '0;
            cfg_reg.vec_c    <= '0;
            cfg_reg.radius   <= '0;
            cfg_reg.stride_y <= STRIDE_W'(1);
            cfg_reg.stride_z <= STRIDE_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/lss_mul_unit.sv
// ----------------------------------------------------------------------------
// Shared multiplier unit
// Three signed multiplier lanes with registered products and operation tag.
// ----------------------------------------------------------------------------
module lss_mul_unit import lss_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mul_op_t                  mul_op,
    input  logic signed [MUL_W-1:0]  mul_a [LANES],
    input  logic signed [MUL_W-1:0]  mul_b [LANES],
    output mul_op_t                  prod_op,
    output logic signed [PROD_W-1:0] prod [LANES]
);

    mul_op_t                  op_reg;
    logic signed [PROD_W-1:0] prod_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= OP_NONE;
        else
            op_reg <= mul_op;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
            prod_reg[l] <= mul_a[l] * mul_b[l];
    end

    assign prod_op = op_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            prod[l] = prod_reg[l];
    end

endmodule

### src/lss_engine.sv
// ----------------------------------------------------------------------------
// Selector sequencer and datapath
// Schedules position, radius, index and neighbor distance work on the
// shared multiplier and keeps the running minimum and the slot counter.
// ----------------------------------------------------------------------------
module lss_engine import lss_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     start,
    input  in_item_t                 item,
    output logic                     idle,
    output logic                     res_valid,
    output out_item_t                res,
    input  logic                     res_take,
    output mul_op_t                  mul_op,
    output logic signed [MUL_W-1:0]  mul_a [LANES],
    output logic signed [MUL_W-1:0]  mul_b [LANES],
    input  mul_op_t                  prod_op,
    input  logic signed [PROD_W-1:0] prod [LANES]
);

    state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] u_reg, u_next;
    logic [1:0] v_reg, v_next;
    logic [1:0] w_reg, w_next;
    logic mag_valid_reg, mag_valid_next;
    logic dsum_valid_reg, dsum_valid_next;
    logic [SLOT_W-1:0] count_reg, count_next;

    logic signed [OFFSET_BITS-1:0] oi_reg, oi_next;
    logic signed [OFFSET_BITS-1:0] oj_reg, oj_next;
    logic signed [OFFSET_BITS-1:0] ok_reg, ok_next;
    logic signed [POS_ACC_W-1:0] pos_reg [LANES];
    logic signed [POS_ACC_W-1:0] pos_next [LANES];
    logic [MAG_W-1:0] mag_reg [LANES];
    logic [MAG_W-1:0] mag_next [LANES];
    logic [DSUM_W-1:0] dsum_reg, dsum_next;
    logic [BEST_W-1:0] best_reg, best_next;
    logic [R2_W-1:0] r2_reg, r2_next;
    logic [FLAT_W-1:0] flat_reg, flat_next;

    logic signed [LP_W-1:0] lp [LANES];
    logic signed [DF_W-1:0] df [LANES];
    logic [DF_W-1:0] mag_full [LANES];
    logic last_nb;
    logic drained;
    logic in_ball;

    assign last_nb = (u_reg == NB_POS) && (v_reg == NB_POS) && (w_reg == NB_POS);
    assign drained = !mag_valid_reg && (prod_op != OP_DIST) && !dsum_valid_reg;
    assign in_ball = CMP_W'(best_reg) < CMP_W'(r2_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_POS;
            S_POS:
                if (cnt_reg == TERM_C)
                    state_next = S_MISC;
            S_MISC:
                state_next = S_FLAT;
            S_FLAT:
                state_next = S_DIST;
            S_DIST:
                if (last_nb)
                    state_next = S_DRAIN;
            S_DRAIN:
                if (drained)
                    state_next = S_DONE;
            S_DONE:
                if (res_take)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mul_op = OP_NONE;
        for (int l = 0; l < LANES; l++)
        begin
            mul_a[l] = '0;
            mul_b[l] = '0;
        end
        case (state_reg)
            S_POS:
            begin
                mul_op = OP_POS;
                for (int ax = 0; ax < LANES; ax++)
                begin
                    case (cnt_reg)
                        TERM_A:
                        begin
                            mul_a[ax] = MUL_W'(oi_reg);
                            mul_b[ax] = MUL_W'(get_comp(cfg.vec_a, 2'(ax)));
                        end
                        TERM_B:
                        begin
                            mul_a[ax] = MUL_W'(oj_reg);
                            mul_b[ax] = MUL_W'(get_comp(cfg.vec_b, 2'(ax)));
                        end
                        default:
                        begin
                            mul_a[ax] = MUL_W'(ok_reg);
                            mul_b[ax] = MUL_W'(get_comp(cfg.vec_c, 2'(ax)));
                        end
                    endcase
                end
            end
            S_MISC:
            begin
                mul_op   = OP_MISC;
                mul_a[0] = MUL_W'(cfg.radius);
                mul_b[0] = MUL_W'(cfg.radius);
                mul_a[1] = MUL_W'(cfg.stride_y);
                mul_b[1] = MUL_W'(cfg.stride_z);
                mul_a[2] = MUL_W'(oj_reg);
                mul_b[2] = MUL_W'(cfg.stride_z);
            end
            S_FLAT:
            begin
                mul_op   = OP_FLAT;
                mul_a[0] = MUL_W'(oi_reg);
                mul_b[0] = MUL_W'(prod[1][SYZ_W-1:0]);
            end
            default:
            begin
                if (mag_valid_reg)
                begin
                    mul_op = OP_DIST;
                    for (int l = 0; l < LANES; l++)
                    begin
                        mul_a[l] = MUL_W'(mag_reg[l]);
                        mul_b[l] = MUL_W'(mag_reg[l]);
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        for (int ax = 0; ax < LANES; ax++)
        begin
            lp[ax] = lat_term(u_reg, get_comp(cfg.vec_a, 2'(ax)))
                   + lat_term(v_reg, get_comp(cfg.vec_b, 2'(ax)))
                   + lat_term(w_reg, get_comp(cfg.vec_c, 2'(ax)));
            df[ax] = DF_W'(lp[ax]) - DF_W'(pos_reg[ax]);
            mag_full[ax] = df[ax][DF_W-1] ? -df[ax] : df[ax];
            mag_next[ax] = (mag_full[ax] > DIFF_CLAMP) ? DIFF_CLAMP[MAG_W-1:0]
                                                       : mag_full[ax][MAG_W-1:0];
        end
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        w_next          = w_reg;
        count_next      = count_reg;
        oi_next         = oi_reg;
        oj_next         = oj_reg;
        ok_next         = ok_reg;
        dsum_next       = dsum_reg;
        best_next       = best_reg;
        r2_next         = r2_reg;
        flat_next       = flat_reg;
        mag_valid_next  = (state_reg == S_DIST);
        dsum_valid_next = (prod_op == OP_DIST);
        for (int l = 0; l < LANES; l++)
            pos_next[l] = pos_reg[l];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    oi_next   = item.offset_i;
                    oj_next   = item.offset_j;
                    ok_next   = item.offset_k;
                    cnt_next  = TERM_A;
                    u_next    = NB_NEG;
                    v_next    = NB_NEG;
                    w_next    = NB_NEG;
                    best_next = DIST_CAP;
                    for (int l = 0; l < LANES; l++)
                        pos_next[l] = '0;
                    if (item.restart)
                        count_next = '0;
                end
            end
            S_POS:
                cnt_next = cnt_reg + 2'd1;
            S_DIST:
            begin
                if (w_reg == NB_POS)
                begin
                    w_next = NB_NEG;
                    if (v_reg == NB_POS)
                    begin
                        v_next = NB_NEG;
                        u_next = u_reg + 2'd1;
                    end
                    else
                    begin
                        v_next = v_reg + 2'd1;
                    end
                end
                else
                begin
                    w_next = w_reg + 2'd1;
                end
            end
            S_DONE:
            begin
                if (res_take && in_ball)
                    count_next = count_reg + SLOT_W'(1);
            end
            default:
                cnt_next = cnt_reg;
        endcase

        case (prod_op)
            OP_POS:
            begin
                for (int l = 0; l < LANES; l++)
                    pos_next[l] = pos_reg[l] + POS_ACC_W'(prod[l]);
            end
            OP_MISC:
            begin
                r2_next   = prod[0][R2_W-1:0];
                flat_next = FLAT_W'(ok_reg) + prod[2][FLAT_W-1:0];
            end
            OP_FLAT:
                flat_next = flat_reg + prod[0][FLAT_W-1:0];
            OP_DIST:
                dsum_next = prod[0][DSUM_W-1:0] + prod[1][DSUM_W-1:0]
                          + prod[2][DSUM_W-1:0];
            default:
                dsum_next = dsum_reg;
        endcase

        if (dsum_valid_reg && (dsum_reg < DSUM_W'(best_reg)))
            best_next = dsum_reg[BEST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= TERM_A;
            u_reg          <= NB_NEG;
            v_reg          <= NB_NEG;
            w_reg          <= NB_NEG;
            mag_valid_reg  <= 1'b0;
            dsum_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            u_reg          <= u_next;
            v_reg          <= v_next;
            w_reg          <= w_next;
            mag_valid_reg  <= mag_valid_next;
            dsum_valid_reg <= dsum_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oi_reg   <= oi_next;
        oj_reg   <= oj_next;
        ok_reg   <= ok_next;
        dsum_reg <= dsum_next;
        best_reg <= best_next;
        r2_reg   <= r2_next;
        flat_reg <= flat_next;
        for (int l = 0; l < LANES; l++)
        begin
            pos_reg[l] <= pos_next[l];
            mag_reg[l] <= mag_next[l];
        end
    end

    always_comb
    begin
        idle            = (state_reg == S_IDLE);
        res_valid       = (state_reg == S_DONE);
        res.inside_res  = in_ball;
        res.pos_x       = sat_pos(pos_reg[0]);
        res.pos_y       = sat_pos(pos_reg[1]);
        res.pos_z       = sat_pos(pos_reg[2]);
        res.min_dist_sq = DIST_OUT_W'(best_reg);
        res.flat_index  = flat_reg;
        res.slot        = in_ball ? count_reg : '0;
    end

endmodule

### src/lattice_sphere_cell_selector.sv
// ----------------------------------------------------------------------------
// Lattice sphere cell selector
// Forms the position of an integer cell offset, its minimum squared distance
// to the 27 nearest lattice points, the ball test, flat index and slot number.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid/in_ready carrying offsets and a restart flag;
// each request yields exactly one result on out_valid/out_ready.
// The configuration port takes one register write per cycle with cfg_we and
// must only be written while no request is in progress.
// A new request is taken only once the previous result has moved into the
// output register and the engine is idle again. Each request makes 27
// neighbor distance passes through the shared three-lane multiplier, plus
// three position passes, two setup passes and the drain of its magnitude,
// square and minimum pipeline.
// The output register holds a result while the receiver stalls; the next
// request is still accepted and worked on, and only its final step waits.
// Reset clears the slot counter, the sequencer state and out_valid; the cell
// vectors and radius return to zero and the strides to one.
// ----------------------------------------------------------------------------
module lattice_sphere_cell_selector import lss_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                     cfg;
    logic                     idle;
    logic                     start;
    logic                     res_valid;
    logic                     res_take;
    out_item_t                res;
    mul_op_t                  mul_op;
    mul_op_t                  prod_op;
    logic signed [MUL_W-1:0]  mul_a [LANES];
    logic signed [MUL_W-1:0]  mul_b [LANES];
    logic signed [PROD_W-1:0] prod [LANES];

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    lss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lss_mul_unit u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .mul_op  (mul_op),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .prod_op (prod_op),
        .prod    (prod)
    );

    lss_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (start),
        .item      (in_data),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .mul_op    (mul_op),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .prod_op   (prod_op),
        .prod      (prod)
    );

    assign in_ready = idle;
    assign start    = in_valid && idle;
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### src/lss_checker.sv
// ----------------------------------------------------------------------------
// Cell selector port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module lss_checker import lss_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled result changed or was dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Block took a second request while busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.inside_res || (out_data.slot == '0)))
        else $error("Result outside the ball carries a slot number.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.min_dist_sq <= DIST_OUT_W'(DIST_CAP)))
        else $error("Minimum distance exceeds the cap.");

endmodule

bind lattice_sphere_cell_selector lss_checker u_lss_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice sphere cell selector testbench
// Drives cell offset requests through the valid/ready input and checks every
// result against a cycle-free model of the position, minimum lattice
// distance, ball test, flat index and slot numbering. The run covers reset
// values, orthogonal and skewed cells, saturation, zero strides, random
// geometry, sender bursts with gaps, receiver stalls and a long output hold.
// ----------------------------------------------------------------------------
module tb;
    import lss_pkg::*;

    localparam int CYCLE_LIMIT     = 1500000;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int DRAIN_CYCLES    = 40;
    localparam longint unsigned DIST_LIMIT = 64'd100000 << (2 * FRAC_BITS);
    localparam longint unsigned DIFF_LIMIT = 64'd1 << 29;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_LONG_STALLS
    } rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [CFG_DATA_W-1:0] lattice_a = '0;
    logic [CFG_DATA_W-1:0] lattice_b = '0;
    logic [CFG_DATA_W-1:0] lattice_c = '0;
    logic [RADIUS_W-1:0]   radius_q = '0;
    logic [STRIDE_W-1:0]   stride_y_q = STRIDE_W'(1);
    logic [STRIDE_W-1:0]   stride_z_q = STRIDE_W'(1);
    logic [SLOT_W-1:0]     slot_count = '0;

    out_item_t expected_cells[$];

    int       error_count = 0;
    int       requests_sent = 0;
    int       results_seen = 0;
    int       inside_seen = 0;
    int       settings_count = 0;
    int       cycle_count = 0;
    bit       gaps_on = 1'b0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    bit       hold_off_req = 1'b0;
    int       hold_left = 0;
    int       rx_run = 0;
    bit       rx_level = 1'b0;

    lattice_sphere_cell_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: cycle limit reached with %0d results pending",
                     expected_cells.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint comp_of(input logic [CFG_DATA_W-1:0] vec, input int axis);
        logic signed [COMP_BITS-1:0] c;
        c = vec[axis*COMP_BITS +: COMP_BITS];
        return longint'(c);
    endfunction

    function automatic out_item_t predict_cell(input in_item_t req);
        out_item_t res;
        longint oi, oj, ok, lp, df, flat, hi, lo, sat;
        longint pos [3];
        longint ca [3];
        longint cb [3];
        longint cc [3];
        longint unsigned mag, d, best, r2;
        oi = longint'($signed(req.offset_i));
        oj = longint'($signed(req.offset_j));
        ok = longint'($signed(req.offset_k));
        if (req.restart)
            slot_count = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            ca[ax] = comp_of(lattice_a, ax);
            cb[ax] = comp_of(lattice_b, ax);
            cc[ax] = comp_of(lattice_c, ax);
            pos[ax] = oi * ca[ax] + oj * cb[ax] + ok * cc[ax];
        end
        best = DIST_LIMIT;
        for (int u = -1; u <= 1; u++)
            for (int v = -1; v <= 1; v++)
                for (int w = -1; w <= 1; w++)
                begin
                    d = 0;
                    for (int ax = 0; ax < 3; ax++)
                    begin
                        lp = u * ca[ax] + v * cb[ax] + w * cc[ax];
                        df = lp - pos[ax];
                        mag = (df < 0) ? longint'(-df) : longint'(df);
                        if (mag > DIFF_LIMIT)
                            mag = DIFF_LIMIT;
                        d += mag * mag;
                    end
                    if (d < best)
                        best = d;
                end
        r2 = 64'(radius_q) * 64'(radius_q);
        hi = (64'sd1 <<< (POS_W - 1)) - 1;
        lo = -hi - 1;
        res = '0;
        res.inside_res = (best < r2);
        for (int ax = 0; ax < 3; ax++)
        begin
            sat = pos[ax];
            if (sat > hi)
                sat = hi;
            if (sat < lo)
                sat = lo;
            case (ax)
                0: res.pos_x = POS_W'(sat);
                1: res.pos_y = POS_W'(sat);
                default: res.pos_z = POS_W'(sat);
            endcase
        end
        res.min_dist_sq = DIST_OUT_W'(best);
        flat = ok + oj * longint'(stride_z_q) + oi * longint'(stride_y_q) * longint'(stride_z_q);
        res.flat_index = FLAT_W'(flat);
        if (res.inside_res)
        begin
            res.slot = slot_count;
            slot_count = slot_count + 1'b1;
        end
        return res;
    endfunction

    function automatic in_item_t make_request(input int i, input int j, input int k,
                                              input bit restart);
        in_item_t item;
        item.offset_i = OFFSET_BITS'(i);
        item.offset_j = OFFSET_BITS'(j);
        item.offset_k = OFFSET_BITS'(k);
        item.restart  = restart;
        return item;
    endfunction

    function automatic int rand_offset(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] make_vec(input int lim);
        int x, y, z;
        x = rand_offset(lim);
        y = rand_offset(lim);
        z = rand_offset(lim);
        return {COMP_BITS'(z), COMP_BITS'(y), COMP_BITS'(x)};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_checker
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cells.size() == 0)
                report_mismatch("result with no request pending", out_data.slot, 0);
            else
            begin
                want = expected_cells.pop_front();
                if (out_data.inside_res !== want.inside_res)
                    report_mismatch("inside_res", out_data.inside_res, want.inside_res);
                if (out_data.pos_x !== want.pos_x)
                    report_mismatch("pos_x", out_data.pos_x, want.pos_x);
                if (out_data.pos_y !== want.pos_y)
                    report_mismatch("pos_y", out_data.pos_y, want.pos_y);
                if (out_data.pos_z !== want.pos_z)
                    report_mismatch("pos_z", out_data.pos_z, want.pos_z);
                if (out_data.min_dist_sq !== want.min_dist_sq)
                    report_mismatch("min_dist_sq", out_data.min_dist_sq, want.min_dist_sq);
                if (out_data.flat_index !== want.flat_index)
                    report_mismatch("flat_index", out_data.flat_index, want.flat_index);
                if (out_data.slot !== want.slot)
                    report_mismatch("slot", out_data.slot, want.slot);
            end
            results_seen++;
            if (out_data.inside_res === 1'b1)
                inside_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_mode == RX_ALWAYS)
            out_ready <= 1'b1;
        else
        begin
            if (rx_run == 0)
            begin
                rx_level = !rx_level;
                if (rx_level)
                    rx_run = $urandom_range(1, 12);
                else if (rx_mode == RX_LONG_STALLS)
                    rx_run = $urandom_range(10, 70);
                else
                    rx_run = $urandom_range(1, 6);
            end
            rx_run--;
            out_ready <= rx_level;
        end
    end

    task automatic send_request(input in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(1, 50) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        expected_cells.push_back(predict_cell(item));
        requests_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] b,
                                  input logic [CFG_DATA_W-1:0] c, input logic [RADIUS_W-1:0] rad,
                                  input logic [STRIDE_W-1:0] sy, input logic [STRIDE_W-1:0] sz);
        wait_idle();
        write_reg(REG_CELL_A, a);
        write_reg(REG_CELL_B, b);
        write_reg(REG_CELL_C, c);
        write_reg(REG_RADIUS, CFG_DATA_W'(rad));
        write_reg(REG_STRIDE_Y, CFG_DATA_W'(sy));
        write_reg(REG_STRIDE_Z, CFG_DATA_W'(sz));
        cfg_we <= 1'b0;
        lattice_a  = a;
        lattice_b  = b;
        lattice_c  = c;
        radius_q   = rad;
        stride_y_q = sy;
        stride_z_q = sz;
        settings_count++;
    endtask

    task automatic test_reset_defaults();
        send_request(make_request(127, 127, 127, 1'b0));
        send_request(make_request(-127, -127, -127, 1'b1));
        send_request(make_request(0, 0, 0, 1'b0));
    endtask

    task automatic test_directed_geometry();
        logic [COMP_BITS-1:0] unit;
        unit = COMP_BITS'(4096);
        apply_settings({21'd0, 21'd0, unit}, {21'd0, unit, 21'd0}, {unit, 21'd0, 21'd0},
                       RADIUS_W'(6144), STRIDE_W'(1023), STRIDE_W'(1023));
        send_request(make_request(0, 0, 0, 1'b1));
        send_request(make_request(1, 0, 0, 1'b0));
        send_request(make_request(2, 0, 0, 1'b0));
        send_request(make_request(0, -2, 0, 1'b0));
        send_request(make_request(3, 0, 0, 1'b0));
        send_request(make_request(2, 2, 0, 1'b0));
        send_request(make_request(1, 1, 1, 1'b0));
        send_request(make_request(0, 0, 0, 1'b1));
        send_request(make_request(127, 127, 127, 1'b0));
        send_request(make_request(-127, -127, -127, 1'b0));
        send_request(make_request(127, -127, 1, 1'b0));
    endtask

    task automatic test_saturation_and_strides();
        logic [COMP_BITS-1:0] cmax, cmin, unit;
        cmax = {1'b0, {(COMP_BITS-1){1'b1}}};
        cmin = {1'b1, {(COMP_BITS-1){1'b0}}};
        unit = COMP_BITS'(4096);
        apply_settings({3{cmax}}, {3{cmax}}, {3{cmax}}, {RADIUS_W{1'b1}},
                       STRIDE_W'(1023), STRIDE_W'(0));
        send_request(make_request(127, 127, 127, 1'b0));
        send_request(make_request(-127, -127, -127, 1'b0));
        send_request(make_request(1, 0, 0, 1'b0));
        send_request(make_request(0, 0, 0, 1'b0));
        apply_settings({3{cmin}}, {3{cmax}}, '0, '0, STRIDE_W'(0), STRIDE_W'(1023));
        send_request(make_request(127, -127, 5, 1'b0));
        send_request(make_request(-127, 127, -5, 1'b0));
        send_request(make_request(0, 0, 0, 1'b1));
        apply_settings({21'd0, 21'd0, unit}, {21'd0, unit, 21'd0}, {unit, 21'd0, 21'd0},
                       {RADIUS_W{1'b1}}, STRIDE_W'(1), STRIDE_W'(1));
        send_request(make_request(127, 0, 0, 1'b0));
        send_request(make_request(127, 127, 127, 1'b0));
        send_request(make_request(-127, -127, -127, 1'b0));
    endtask

    task automatic test_random_cells(input int phases, input int per_phase);
        logic [CFG_DATA_W-1:0] va, vb, vc;
        logic [RADIUS_W-1:0]   rad;
        logic [STRIDE_W-1:0]   sy, sz;
        int lim, span;
        for (int p = 0; p < phases; p++)
        begin
            if (p % 4 == 3)
            begin
                va  = CFG_DATA_W'({$urandom, $urandom});
                vb  = CFG_DATA_W'({$urandom, $urandom});
                vc  = CFG_DATA_W'({$urandom, $urandom});
                rad = RADIUS_W'($urandom);
                sy  = STRIDE_W'($urandom);
                sz  = STRIDE_W'($urandom);
            end
            else
            begin
                lim = $urandom_range(256, 16384);
                va  = make_vec(lim);
                vb  = make_vec(lim);
                vc  = make_vec(lim);
                rad = RADIUS_W'($urandom_range(0, 4 * lim));
                sy  = STRIDE_W'($urandom_range(1, 1023));
                sz  = STRIDE_W'($urandom_range(1, 1023));
            end
            apply_settings(va, vb, vc, rad, sy, sz);
            gaps_on = ($urandom_range(0, 3) != 0);
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            for (int n = 0; n < per_phase; n++)
            begin
                span = ($urandom_range(0, 4) == 0) ? 127 : $urandom_range(1, 5);
                send_request(make_request(rand_offset(span), rand_offset(span),
                                          rand_offset(span), $urandom_range(0, 19) == 0));
            end
        end
    endtask

    task automatic test_output_stall();
        apply_settings(make_vec(4096), make_vec(4096), make_vec(4096),
                       RADIUS_W'(12000), STRIDE_W'($urandom_range(1, 1023)),
                       STRIDE_W'($urandom_range(1, 1023)));
        gaps_on = 1'b0;
        rx_mode = RX_RANDOM;
        hold_off_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_request(make_request(rand_offset(4), rand_offset(4), rand_offset(4),
                                      n == 0));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        rx_mode = RX_RANDOM;
        test_directed_geometry();
        gaps_on = 1'b1;
        rx_mode = RX_LONG_STALLS;
        test_saturation_and_strides();
        test_random_cells(10, 150);
        test_output_stall();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d requests over %0d register settings, %0d results checked,",
                 requests_sent, settings_count, results_seen);
        $display("%0d of them inside the ball, with %0d mismatches.", inside_seen, error_count);
        if (error_count == 0 && expected_cells.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
